// ===== hdl/sbmq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sbmq_pkg;

  // Default sizes of the shared store.
  localparam int NUM_SLOTS_DEF  = 256;
  localparam int NUM_QUEUES_DEF = 8;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed widths of the channel fields.
  localparam int QID_W    = 3;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;

  // Request codes.
  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic              req_type;
    logic [QID_W-1:0]  queue_id;
    logic [WORD_W-1:0] data_in;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   data_out;
  } rsp_t;

endpackage

`default_nettype wire

// ===== hdl/sbmq_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface sbmq_req_if
  import sbmq_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [QID_W-1:0]         queue_id;
  logic signed [WORD_W-1:0] data_in;

  modport source (output valid, output req_type, output queue_id, output data_in,
                  input ready);
  modport sink (input valid, input req_type, input queue_id, input data_in,
                output ready);
endinterface

interface sbmq_rsp_if
  import sbmq_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [WORD_W-1:0] data_out;

  modport source (output valid, output status, output data_out, input ready);
  modport sink (input valid, input status, input data_out, output ready);
endinterface

`default_nettype wire

// ===== hdl/sbmq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sbmq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic                             re,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the address being written returns the new data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sbmq_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sbmq_core
  import sbmq_pkg::*;
#(
  parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
  parameter int NUM_QUEUES = NUM_QUEUES_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic launch,
  input  wire req_t new_req,
  input  wire logic commit,
  input  wire req_t cur_req,
  output rsp_t      result
);

  localparam int PTR_W  = $clog2(NUM_SLOTS + 1);
  localparam int ADDR_W = $clog2(NUM_SLOTS);
  localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(NUM_SLOTS);

  logic [PTR_W-1:0] head [NUM_QUEUES];
  logic [PTR_W-1:0] tail [NUM_QUEUES];
  logic [PTR_W-1:0] free_head;
  // Slots at or above fill have never been handed out; their link is slot + 1.
  logic [PTR_W-1:0] fill;

  logic [PTR_W-1:0] head_next [NUM_QUEUES];
  logic [PTR_W-1:0] tail_next [NUM_QUEUES];
  logic [PTR_W-1:0] free_head_next;
  logic [PTR_W-1:0] fill_next;

  logic                  link_we;
  logic [ADDR_W-1:0]     link_waddr;
  logic [PTR_W-1:0]      link_wdata;
  logic [ADDR_W-1:0]     link_raddr;
  logic [PTR_W-1:0]      link_rdata;
  logic                  data_we;
  logic [ADDR_W-1:0]     data_waddr;
  logic [DATA_WIDTH-1:0] data_wdata;
  logic [ADDR_W-1:0]     data_raddr;
  logic [DATA_WIDTH-1:0] data_rdata;

  logic [QIDX_W-1:0] cq;
  logic [QIDX_W-1:0] nq;
  logic              cq_ok;
  logic              nq_ok;
  logic [PTR_W-1:0]  cur_head;
  logic [PTR_W-1:0]  cur_tail;
  logic [PTR_W-1:0]  slot;
  logic [PTR_W-1:0]  slot_link;
  logic [PTR_W-1:0]  new_head;
  logic [PTR_W-1:0]  deq_next;

  assign cq    = QIDX_W'(cur_req.queue_id);
  assign nq    = QIDX_W'(new_req.queue_id);
  assign cq_ok = (32'(cur_req.queue_id) < NUM_QUEUES);
  assign nq_ok = (32'(new_req.queue_id) < NUM_QUEUES);

  assign cur_head = cq_ok ? head[cq] : NULL_PTR;
  assign cur_tail = cq_ok ? tail[cq] : NULL_PTR;
  assign slot     = (cur_req.req_type == REQ_DEQ) ? cur_head : free_head;
  assign slot_link = (slot >= fill) ? (slot + PTR_W'(1)) : link_rdata;
  // The tail's link is never maintained, so a lone element ends the queue.
  assign deq_next = (cur_head == cur_tail) ? NULL_PTR : slot_link;

  always_comb begin
    head_next      = head;
    tail_next      = tail;
    free_head_next = free_head;
    fill_next      = fill;
    link_we        = 1'b0;
    link_waddr     = slot[ADDR_W-1:0];
    link_wdata     = free_head;
    data_we        = 1'b0;
    data_waddr     = slot[ADDR_W-1:0];
    data_wdata     = DATA_WIDTH'($unsigned(cur_req.data_in));
    result.status   = ST_OK;
    result.data_out = '0;

    if (cur_req.req_type == REQ_ENQ) begin
      if (!cq_ok || (free_head == NULL_PTR)) begin
        result.status = ST_FULL;
      end else if (commit) begin
        free_head_next = slot_link;
        if (slot == fill) begin
          fill_next = fill + PTR_W'(1);
        end
        if (cur_head == NULL_PTR) begin
          head_next[cq] = slot;
        end else begin
          link_we    = 1'b1;
          link_waddr = cur_tail[ADDR_W-1:0];
          link_wdata = slot;
        end
        tail_next[cq] = slot;
        data_we       = 1'b1;
      end
    end else begin
      if (!cq_ok || (cur_head == NULL_PTR)) begin
        result.status = ST_EMPTY;
      end else begin
        result.data_out = WORD_W'(data_rdata);
        if (commit) begin
          head_next[cq] = deq_next;
          if (deq_next == NULL_PTR) begin
            tail_next[cq] = NULL_PTR;
          end
          link_we        = 1'b1;
          free_head_next = slot;
        end
      end
    end
  end

  // Reads for the next request use the state as it stands after this commit.
  assign new_head   = nq_ok ? head_next[nq] : NULL_PTR;
  assign link_raddr = (new_req.req_type == REQ_DEQ) ? new_head[ADDR_W-1:0]
                                                    : free_head_next[ADDR_W-1:0];
  assign data_raddr = new_head[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head[i] <= NULL_PTR;
        tail[i] <= NULL_PTR;
      end
      free_head <= '0;
      fill      <= '0;
    end else begin
      head      <= head_next;
      tail      <= tail_next;
      free_head <= free_head_next;
      fill      <= fill_next;
    end
  end

  sbmq_ram #(
    .WIDTH (PTR_W),
    .DEPTH (NUM_SLOTS)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (launch),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  sbmq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (NUM_SLOTS)
  ) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (data_waddr),
    .wdata (data_wdata),
    .re    (launch),
    .raddr (data_raddr),
    .rdata (data_rdata)
  );

endmodule

`default_nettype wire

// ===== hdl/shared_buffer_multi_queue_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel | Dir | Beat contents
// --------+-----+-----------------------------------------
// req     | in  | req_type, queue_id, data_in
// rsp     | out | status, data_out
//
// One request is taken per cycle while req.ready is high; the registered
// link and data memory reads feed the response, held in an output register.
// After reset every queue is empty and all slots are free; no clearing pass.
// A response held by rsp.ready low holds the request behind it in the
// memory read stage, and req.ready drops only when both stages are full.

module shared_buffer_multi_queue_unit
  import sbmq_pkg::*;
#(
  parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
  parameter int NUM_QUEUES = NUM_QUEUES_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  sbmq_req_if.sink   req,
  sbmq_rsp_if.source rsp
);

  logic stage_valid;
  req_t stage_req;
  req_t new_req;
  logic out_valid;
  rsp_t out_rsp;
  rsp_t result;
  logic launch;
  logic commit;

  assign new_req.req_type = req.req_type;
  assign new_req.queue_id = req.queue_id;
  assign new_req.data_in  = $unsigned(req.data_in);

  assign commit    = stage_valid && (!out_valid || rsp.ready);
  assign req.ready = !stage_valid || commit;
  assign launch    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (launch) begin
        stage_valid <= 1'b1;
      end else if (commit) begin
        stage_valid <= 1'b0;
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (launch) begin
      stage_req <= new_req;
    end
    if (commit) begin
      out_rsp <= result;
    end
  end

  sbmq_core #(
    .NUM_SLOTS  (NUM_SLOTS),
    .NUM_QUEUES (NUM_QUEUES),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .launch  (launch),
    .new_req (new_req),
    .commit  (commit),
    .cur_req (stage_req),
    .result  (result)
  );

  assign rsp.valid    = out_valid;
  assign rsp.status   = out_rsp.status;
  assign rsp.data_out = $signed(out_rsp.data_out);

endmodule

`default_nettype wire

// ===== sim/shared_buffer_multi_queue_unit_tb.sv =====
`timescale 1ns / 1ps

module shared_buffer_multi_queue_unit_tb;
  import sbmq_pkg::*;

  localparam int SLOTS = NUM_SLOTS_DEF;
  localparam int QUEUES = NUM_QUEUES_DEF;
  localparam int PTR_W = $clog2(SLOTS + 1);
  localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(SLOTS);
  localparam int RANDOM_ITEMS = 1100;
  localparam int MIXED_LEN = 150;
  localparam int PAST_LIMIT = 10;
  localparam int HOLD_CYCLES = 80;
  localparam int SETTLE_CYCLES = 20;
  localparam int CYCLE_LIMIT = 300000;
  localparam int MAX_PRINTED = 100;

  typedef enum {GEN_MIXED, GEN_FILL, GEN_DRAIN} gen_mode_t;

  logic clk;
  logic rst;

  sbmq_req_if req_ch ();
  sbmq_rsp_if rsp_ch ();

  shared_buffer_multi_queue_unit DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Requests still to be offered, with a flag that makes the sender wait
  // for every outstanding response before offering that request.
  req_t requests_to_send[$];
  bit   wait_for_drain[$];
  rsp_t answers_due[$];

  // Shadow of the linked-list state.
  logic [PTR_W-1:0]  pred_head [QUEUES];
  logic [PTR_W-1:0]  pred_tail [QUEUES];
  logic [PTR_W-1:0]  pred_link [SLOTS];
  logic [PTR_W-1:0]  pred_free;
  logic [WORD_W-1:0] pred_word [SLOTS];

  // Occupancy as seen while generating, used only to shape the stimulus.
  int gen_depth [QUEUES];
  int gen_total;

  int   total_items;
  int   reqs_taken;
  int   rsps_seen;
  int   mismatches;
  int   holds_done;
  int   hold_left;
  int   cycle_count;
  bit   offer;
  rsp_t predicted;
  rsp_t wanted;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [WORD_W-1:0] edge_word(input int idx);
    case (idx)
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4: return 32'h0000_0001;
      5: return 32'haaaa_aaaa;
      6: return 32'h5555_5555;
      default: return 32'h1234_5678;
    endcase
  endfunction

  // Idle percentage for one side, by thirds of the run: the sender idles
  // lightly and the receiver heavily, then the reverse, then neither.
  function automatic int idle_pct(input bit receiver_side);
    int third;
    third = (total_items == 0) ? 0 : (reqs_taken * 3) / total_items;
    case (third)
      0: return receiver_side ? 51 : 14;
      1: return receiver_side ? 14 : 51;
      default: return 0;
    endcase
  endfunction

  task automatic add_req(input logic kind, input int q, input logic [WORD_W-1:0] d,
                         input bit drain_first);
    req_t r;
    r.req_type = kind;
    r.queue_id = QID_W'(q);
    r.data_in = d;
    requests_to_send.push_back(r);
    wait_for_drain.push_back(drain_first);
    if (kind == REQ_ENQ && gen_total < SLOTS) begin
      gen_depth[q]++;
      gen_total++;
    end else if (kind == REQ_DEQ && gen_depth[q] > 0) begin
      gen_depth[q]--;
      gen_total--;
    end
  endtask

  task automatic advance_queues(input req_t r, output rsp_t res);
    logic [PTR_W-1:0] slot;
    int q;
    q = r.queue_id;
    res.status = ST_OK;
    res.data_out = '0;
    if (r.req_type == REQ_ENQ) begin
      if (q >= QUEUES || pred_free == NULL_PTR) begin
        res.status = ST_FULL;
      end else begin
        slot = pred_free;
        pred_free = pred_link[slot];
        if (pred_head[q] == NULL_PTR) pred_head[q] = slot;
        else pred_link[pred_tail[q]] = slot;
        pred_link[slot] = NULL_PTR;
        pred_tail[q] = slot;
        pred_word[slot] = r.data_in;
      end
    end else begin
      if (q >= QUEUES || pred_head[q] == NULL_PTR) begin
        res.status = ST_EMPTY;
      end else begin
        slot = pred_head[q];
        pred_head[q] = pred_link[slot];
        // Taking the last element leaves the queue with no tail either.
        if (pred_head[q] == NULL_PTR) pred_tail[q] = NULL_PTR;
        pred_link[slot] = pred_free;
        pred_free = slot;
        res.data_out = pred_word[slot];
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    if (mismatches < MAX_PRINTED)
      $display("mismatch at %0t on response %0d: %s is %h, expected %h",
               $time, rsps_seen, what, got, want);
    mismatches++;
  endtask

  initial begin : stimulus
    int q;
    int n;
    int j;
    int k;
    int mixed_left;
    int extra_left;
    bit is_enq;
    bit new_seg;
    gen_mode_t mode;
    logic [WORD_W-1:0] d;

    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_ENQ;
    req_ch.queue_id = '0;
    req_ch.data_in = '0;
    rsp_ch.ready = 1'b0;
    total_items = 0;
    reqs_taken = 0;
    rsps_seen = 0;
    mismatches = 0;

    for (q = 0; q < QUEUES; q++) begin
      pred_head[q] = NULL_PTR;
      pred_tail[q] = NULL_PTR;
      gen_depth[q] = 0;
    end
    for (k = 0; k < SLOTS; k++) begin
      pred_link[k] = PTR_W'(k + 1);
      pred_word[k] = '0;
    end
    pred_free = '0;
    gen_total = 0;

    // Directed: empty dequeue, every queue with the extreme words, a three
    // deep queue drained past its last element, reuse of a freed slot.
    add_req(REQ_DEQ, 0, '0, 1'b0);
    for (q = 0; q < QUEUES; q++) add_req(REQ_ENQ, q, edge_word(q), 1'b0);
    add_req(REQ_ENQ, 0, 32'hdead_beef, 1'b0);
    add_req(REQ_ENQ, 0, 32'h0f0f_f0f0, 1'b0);
    repeat (4) add_req(REQ_DEQ, 0, $urandom(), 1'b0);
    add_req(REQ_ENQ, 0, 32'hcafe_f00d, 1'b0);
    add_req(REQ_DEQ, 0, '0, 1'b0);
    for (q = 1; q < QUEUES; q++) add_req(REQ_DEQ, q, '0, 1'b0);
    add_req(REQ_DEQ, QUEUES - 1, 32'hffff_ffff, 1'b1);

    // Random: mixed traffic, then fill until the free list runs dry, then
    // drain until every queue is empty, over and over.
    mode = GEN_MIXED;
    mixed_left = MIXED_LEN;
    extra_left = PAST_LIMIT;
    new_seg = 1'b1;
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      case (mode)
        GEN_MIXED: is_enq = $urandom_range(99) < 55;
        GEN_FILL: is_enq = $urandom_range(99) < 95;
        default: is_enq = $urandom_range(99) < 8;
      endcase
      q = $urandom_range(QUEUES - 1);
      if (is_enq && mode == GEN_FILL && $urandom_range(1) == 1) q = $urandom_range(2);
      if (!is_enq && mode == GEN_DRAIN && $urandom_range(99) < 80) begin
        n = q;
        for (j = 1; j < QUEUES && gen_depth[q] == 0; j++) q = (n + j) % QUEUES;
      end
      d = ($urandom_range(9) == 0) ? edge_word($urandom_range(3)) : $urandom();
      add_req(is_enq ? REQ_ENQ : REQ_DEQ, q, d, new_seg);
      new_seg = 1'b0;
      case (mode)
        GEN_MIXED: begin
          mixed_left--;
          if (mixed_left == 0) begin
            mode = GEN_FILL;
            extra_left = PAST_LIMIT;
            new_seg = 1'b1;
          end
        end
        GEN_FILL: begin
          if (gen_total == SLOTS) begin
            if (extra_left == 0) begin
              mode = GEN_DRAIN;
              extra_left = PAST_LIMIT;
              new_seg = 1'b1;
            end else begin
              extra_left--;
            end
          end
        end
        default: begin
          if (gen_total == 0) begin
            if (extra_left == 0) begin
              mode = GEN_MIXED;
              mixed_left = MIXED_LEN;
              new_seg = 1'b1;
            end else begin
              extra_left--;
            end
          end
        end
      endcase
    end
    total_items = requests_to_send.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (requests_to_send.size() != 0 || answers_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("shared_buffer_multi_queue_unit regression: pass");
    end else begin
      $display("shared_buffer_multi_queue_unit regression: fail");
    end
    $finish;
  end

  // Request driver: a beat stays offered until it is taken.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      offer = req_ch.valid;
      if (req_ch.valid && req_ch.ready) begin
        advance_queues(requests_to_send.pop_front(), predicted);
        void'(wait_for_drain.pop_front());
        answers_due.push_back(predicted);
        reqs_taken++;
        offer = 1'b0;
      end
      if (!offer && requests_to_send.size() != 0) begin
        if (wait_for_drain[0] && answers_due.size() != 0) begin
          offer = 1'b0;
        end else if ($urandom_range(99) >= idle_pct(1'b0)) begin
          offer = 1'b1;
          req_ch.req_type <= requests_to_send[0].req_type;
          req_ch.queue_id <= requests_to_send[0].queue_id;
          req_ch.data_in <= requests_to_send[0].data_in;
        end
      end
      req_ch.valid <= offer;
    end
  end

  // Long receiver stalls at two points, so the block backs up into its input.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done < 2 && reqs_taken >= (holds_done == 0 ? 200 : 750)) begin
      hold_left <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  // Response monitor.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (answers_due.size() == 0) begin
          report_mismatch("unexpected beat, status", WORD_W'(rsp_ch.status), '0);
        end else begin
          wanted = answers_due.pop_front();
          if (rsp_ch.status !== wanted.status)
            report_mismatch("status", WORD_W'(rsp_ch.status), WORD_W'(wanted.status));
          if (rsp_ch.data_out !== wanted.data_out)
            report_mismatch("data_out", rsp_ch.data_out, wanted.data_out);
        end
        rsps_seen++;
      end
      if (hold_left != 0) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= $urandom_range(99) >= idle_pct(1'b1);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      cycle_count <= 0;
    end else begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("shared_buffer_multi_queue_unit regression: fail");
        $finish;
      end
    end
  end

endmodule

// ===== filelist.f =====
hdl/sbmq_pkg.sv
hdl/sbmq_ifs.sv
hdl/sbmq_ram.sv
hdl/sbmq_core.sv
hdl/shared_buffer_multi_queue_unit.sv
sim/shared_buffer_multi_queue_unit_tb.sv
